/* design/lzed_pkg.sv */
// ----------------------------------------------------------------------------
// lzed_pkg
// Shared types and constants of the lzss entry decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzed_pkg;

  localparam int unsigned WindowSize = 4096;
  localparam int unsigned WinAw      = $clog2(WindowSize);
  localparam int unsigned LenW       = 24;
  localparam int unsigned CopyCntW   = 5;

  localparam logic [7:0]          ModeRaw  = 8'h00;
  localparam logic [7:0]          ModeLzss = 8'h20;
  localparam logic [CopyCntW-1:0] CopyBias = CopyCntW'(3);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       entry_start;
  } lzed_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       data_valid;
    logic       run_last;
    logic       entry_done;
    logic       bad_mode;
  } lzed_out_t;

  // request from the sequencer to the window store
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [WinAw-1:0] rd_addr;
  } lzed_win_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEADER,
    ST_RAW,
    ST_FLAG,
    ST_DATA,
    ST_REFHI,
    ST_COPY_RD,
    ST_COPY_OUT,
    ST_DONE,
    ST_ERROR
  } lzed_state_e;

endpackage

`default_nettype wire

/* design/lzss_entry_decompressor_unit.sv */
// ----------------------------------------------------------------------------
// lzss_entry_decompressor_unit
// Parses an entry header, then passes raw bytes or decodes lzss flags,
// literals and window references into one output byte per result.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  in      | in_valid_i / in_stall_o          | in_data_i  (lzed_in_t)
//  out     | out_valid_o / out_stall_i        | out_data_o (lzed_out_t)
//
//  header, flag, literal and raw bytes are taken while the output register
//  is free; a reference copies 3 to 18 bytes, fewer where the length ends,
//  each read through the window's single registered read port, then output.
//  reset is asynchronous; entry start rewinds the window fill pointer, so
//  there is no clearing pass. input stalls during a copy and while the
//  output register holds an item that is not taken.
`default_nettype none

module lzss_entry_decompressor_unit import lzed_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire lzed_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output lzed_out_t      out_data_o
);

  lzed_state_e          state_q, state_d;
  logic [1:0]           hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]      rem_q, rem_d;
  logic [7:0]           flag_bits_q, flag_bits_d;
  logic [3:0]           flag_cnt_q, flag_cnt_d;
  logic [7:0]           ref_lo_q, ref_lo_d;
  logic [WinAw-1:0]     pos_q, pos_d;
  logic [CopyCntW-1:0]  copy_cnt_q, copy_cnt_d;
  logic                 out_valid_q, out_valid_d;
  lzed_out_t            out_q, out_d;

  lzed_win_req_t        win_req;
  logic [7:0]           win_rd_data;
  logic                 accept, out_free, copying, out_load, do_next, last;
  logic [7:0]           b;
  logic [3:0]           flag_cnt_m1;

  lzed_window u_window (
    .clk_i,
    .rst_ni,
    .req_i     (win_req),
    .rd_data_o (win_rd_data)
  );

  assign copying     = (state_q == ST_COPY_RD) || (state_q == ST_COPY_OUT);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = copying || !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign b           = in_data_i.in_byte;
  assign flag_cnt_m1 = flag_cnt_q - 4'd1;

  always_comb begin
    state_d     = state_q;
    hdr_cnt_d   = hdr_cnt_q;
    rem_d       = rem_q;
    flag_bits_d = flag_bits_q;
    flag_cnt_d  = flag_cnt_q;
    ref_lo_d    = ref_lo_q;
    pos_d       = pos_q;
    copy_cnt_d  = copy_cnt_q;
    out_load    = 1'b0;
    out_d       = out_q;
    do_next     = 1'b0;
    last        = 1'b0;
    win_req     = '0;

    if (accept && in_data_i.entry_start) begin
      win_req.clear = 1'b1;
      rem_d         = {16'h0000, b};
      hdr_cnt_d     = 2'd1;
      flag_bits_d   = '0;
      flag_cnt_d    = '0;
      ref_lo_d      = '0;
      state_d       = ST_HEADER;
    end else begin
      case (state_q)
        ST_HEADER: begin
          if (accept) begin
            case (hdr_cnt_q)
              2'd1: begin
                rem_d[15:8] = b;
                hdr_cnt_d   = 2'd2;
              end
              2'd2: begin
                rem_d[23:16] = b;
                hdr_cnt_d    = 2'd3;
              end
              default: begin
                // mode byte
                hdr_cnt_d = 2'd0;
                if (b != ModeRaw && b != ModeLzss) begin
                  state_d  = ST_ERROR;
                  out_load = 1'b1;
                  out_d    = '{out_byte: 8'h00, data_valid: 1'b0, run_last: 1'b1,
                               entry_done: 1'b0, bad_mode: 1'b1};
                end else if (rem_q == '0) begin
                  state_d  = ST_DONE;
                  out_load = 1'b1;
                  out_d    = '{out_byte: 8'h00, data_valid: 1'b0, run_last: 1'b1,
                               entry_done: 1'b1, bad_mode: 1'b0};
                end else begin
                  state_d = (b == ModeRaw) ? ST_RAW : ST_FLAG;
                end
              end
            endcase
          end
        end
        ST_RAW: begin
          if (accept) begin
            win_req.wr_en   = 1'b1;
            win_req.wr_data = b;
            rem_d           = rem_q - LenW'(1);
            out_load        = 1'b1;
            out_d           = '{out_byte: b, data_valid: 1'b1, run_last: 1'b1,
                                entry_done: (rem_q == LenW'(1)), bad_mode: 1'b0};
            if (rem_q == LenW'(1)) begin
              state_d = ST_DONE;
            end
          end
        end
        ST_FLAG: begin
          if (accept) begin
            flag_bits_d = b;
            flag_cnt_d  = 4'd8;
            state_d     = ST_DATA;
          end
        end
        ST_DATA: begin
          if (accept) begin
            if (flag_bits_q[0]) begin
              win_req.wr_en   = 1'b1;
              win_req.wr_data = b;
              rem_d           = rem_q - LenW'(1);
              out_load        = 1'b1;
              out_d           = '{out_byte: b, data_valid: 1'b1, run_last: 1'b1,
                                  entry_done: (rem_q == LenW'(1)), bad_mode: 1'b0};
              do_next         = 1'b1;
            end else begin
              ref_lo_d = b;
              state_d  = ST_REFHI;
            end
          end
        end
        ST_REFHI: begin
          if (accept) begin
            pos_d      = {b[3:0], ref_lo_q};
            copy_cnt_d = {1'b0, b[7:4]} + CopyBias;
            state_d    = ST_COPY_RD;
          end
        end
        ST_COPY_RD: begin
          win_req.rd_en   = 1'b1;
          win_req.rd_addr = pos_q;
          state_d         = ST_COPY_OUT;
        end
        ST_COPY_OUT: begin
          if (out_free) begin
            last            = (copy_cnt_q == CopyCntW'(1)) || (rem_q == LenW'(1));
            win_req.wr_en   = 1'b1;
            win_req.wr_data = win_rd_data;
            rem_d           = rem_q - LenW'(1);
            pos_d           = pos_q + WinAw'(1);
            copy_cnt_d      = copy_cnt_q - CopyCntW'(1);
            out_load        = 1'b1;
            out_d           = '{out_byte: win_rd_data, data_valid: 1'b1, run_last: last,
                                entry_done: (rem_q == LenW'(1)), bad_mode: 1'b0};
            if (last) begin
              do_next = 1'b1;
            end else begin
              state_d = ST_COPY_RD;
            end
          end
        end
        default: begin
          // idle, done and error drop bytes until the next entry start
        end
      endcase
    end

    // step to the next flag bit once a literal or a copy has finished, or end the entry when the length is reached
    if (do_next) begin
      if (rem_q == LenW'(1)) begin
        state_d = ST_DONE;
      end else begin
        flag_bits_d = {1'b0, flag_bits_q[7:1]};
        flag_cnt_d  = flag_cnt_m1;
        state_d     = (flag_cnt_m1 == 4'd0) ? ST_FLAG : ST_DATA;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hdr_cnt_q   <= '0;
      rem_q       <= '0;
      flag_bits_q <= '0;
      flag_cnt_q  <= '0;
      copy_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hdr_cnt_q   <= hdr_cnt_d;
      rem_q       <= rem_d;
      flag_bits_q <= flag_bits_d;
      flag_cnt_q  <= flag_cnt_d;
      copy_cnt_q  <= copy_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_lo_q <= ref_lo_d;
    pos_q    <= pos_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_copy_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copying |-> in_stall_o)
    else $error("input taken during a copy");

  a_read_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY_RD) |=> (state_q == ST_COPY_OUT))
    else $error("window read not followed by output step");

  a_copy_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copying |-> (copy_cnt_q != '0) && (rem_q != '0))
    else $error("copy running with nothing left to produce");

  a_bad_mode_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bad_mode) |->
      (!out_data_o.data_valid && out_data_o.run_last && !out_data_o.entry_done))
    else $error("bad mode item carries data");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.entry_done) |=> (state_q == ST_DONE))
    else $error("length completed but decoding goes on");

endmodule

`default_nettype wire

/* design/lzed_window.sv */
// ----------------------------------------------------------------------------
// lzed_window
// History window: one write and one registered read per cycle. Writes go
// in order from address zero, so a fill pointer tells written entries from
// cleared ones; a clear only rewinds the pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module lzed_window import lzed_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire lzed_win_req_t req_i,
  output logic [7:0]         rd_data_o
);

  logic [7:0]       mem [WindowSize];
  logic [WinAw-1:0] wr_ptr_q, wr_ptr_d;
  logic             wrap_q, wrap_d;
  logic [7:0]       rd_q;
  logic             rd_ok_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    wrap_d   = wrap_q;
    if (req_i.clear) begin
      wr_ptr_d = '0;
      wrap_d   = 1'b0;
    end else if (req_i.wr_en) begin
      wr_ptr_d = wr_ptr_q + WinAw'(1);
      if (wr_ptr_q == '1) begin
        wrap_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      wrap_q   <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      wrap_q   <= wrap_d;
      if (req_i.rd_en) begin
        // entries past the fill pointer still read as cleared
        rd_ok_q <= wrap_q || (req_i.rd_addr < wr_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && !req_i.clear) begin
      mem[wr_ptr_q] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : 8'h00;

endmodule

`default_nettype wire

/* bench/lzed_scoreboard.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzed_scoreboard
// Watches both channels of the lzss entry decompressor. Every accepted input
// byte is decoded by a local copy of the header, raw, flag, literal and
// window reference logic, and the output bytes it should cause are queued.
// Every accepted output item is checked field by field against the oldest
// queued one.
// ----------------------------------------------------------------------------
module lzed_scoreboard import lzed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  lzed_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  lzed_out_t   out_data_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  logic [7:0]       win_mem [WindowSize];
  logic [WinAw-1:0] wr_pos;
  logic [LenW-1:0]  left_len;
  logic [31:0]      hdr_word;
  logic [1:0]       hdr_cnt;
  logic [7:0]       flags;
  logic [3:0]       flag_left;
  logic [7:0]       ref_lo;
  lzed_state_e      phase;

  lzed_out_t   expected_bytes_q[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned pending;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = pending;
  assign checked_o      = checked;

  task automatic clear_entry();
    for (int i = 0; i < WindowSize; i++) win_mem[i] = 8'h00;
    wr_pos    = '0;
    left_len  = '0;
    hdr_word  = '0;
    hdr_cnt   = '0;
    flags     = '0;
    flag_left = '0;
    ref_lo    = '0;
  endtask

  task automatic store_byte(input logic [7:0] b);
    win_mem[wr_pos] = b;
    wr_pos          = wr_pos + 1'b1;
    left_len        = left_len - 1'b1;
  endtask

  task automatic push_result(input logic [7:0] b, input logic dv, input logic last,
                             input logic done, input logic bad);
    lzed_out_t r;
    r.out_byte   = b;
    r.data_valid = dv;
    r.run_last   = last;
    r.entry_done = done;
    r.bad_mode   = bad;
    expected_bytes_q.push_back(r);
  endtask

  task automatic next_flag_bit();
    if (left_len == '0) begin
      phase = ST_DONE;
    end else begin
      flags     = flags >> 1;
      flag_left = flag_left - 1'b1;
      phase     = (flag_left == '0) ? ST_FLAG : ST_DATA;
    end
  endtask

  task automatic decode_byte(input lzed_in_t item);
    logic [7:0]       b;
    logic [7:0]       mode;
    logic [15:0]      word;
    logic [4:0]       run_len;
    logic [WinAw-1:0] rd_pos;
    logic [7:0]       v;
    b = item.in_byte;
    if (item.entry_start) begin
      clear_entry();
      hdr_word = {24'h0, b};
      hdr_cnt  = 2'd1;
      phase    = ST_HEADER;
    end else begin
      case (phase)
        ST_HEADER: begin
          hdr_word[8*hdr_cnt +: 8] = b;
          if (hdr_cnt < 2'd3) begin
            hdr_cnt = hdr_cnt + 1'b1;
          end else begin
            hdr_cnt  = '0;
            left_len = hdr_word[LenW-1:0];
            mode     = hdr_word[31:24];
            if (mode != ModeRaw && mode != ModeLzss) begin
              phase = ST_ERROR;
              push_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
            end else if (left_len == '0) begin
              phase = ST_DONE;
              push_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            end else begin
              phase = (mode == ModeRaw) ? ST_RAW : ST_FLAG;
            end
          end
        end
        ST_RAW: begin
          store_byte(b);
          if (left_len == '0) phase = ST_DONE;
          push_result(b, 1'b1, 1'b1, left_len == '0, 1'b0);
        end
        ST_FLAG: begin
          flags     = b;
          flag_left = 4'd8;
          phase     = ST_DATA;
        end
        ST_DATA: begin
          if (flags[0]) begin
            store_byte(b);
            push_result(b, 1'b1, 1'b1, left_len == '0, 1'b0);
            next_flag_bit();
          end else begin
            ref_lo = b;
            phase  = ST_REFHI;
          end
        end
        ST_REFHI: begin
          word    = {b, ref_lo};
          run_len = {1'b0, word[15:12]} + CopyBias;
          rd_pos  = word[WinAw-1:0];
          // byte by byte, so an overlapping copy sees what it just wrote
          for (int i = 0; i < run_len; i++) begin
            v      = win_mem[rd_pos];
            rd_pos = rd_pos + 1'b1;
            store_byte(v);
            push_result(v, 1'b1, (i == run_len - 1) || (left_len == '0),
                        left_len == '0, 1'b0);
            if (left_len == '0) break;
          end
          next_flag_bit();
        end
        default: begin
          // idle, done and bad mode ignore the byte
        end
      endcase
    end
  endtask

  task automatic check_result(input lzed_out_t got);
    lzed_out_t exp;
    if (expected_bytes_q.size() == 0) begin
      $display("%0t ns: output item with none expected, got %h", $time, got);
      mismatches++;
    end else begin
      exp = expected_bytes_q.pop_front();
      checked++;
      if (got !== exp) begin
        mismatches++;
        if (got.out_byte !== exp.out_byte)
          $display("%0t ns: out_byte expected %02h got %02h", $time, exp.out_byte,
                   got.out_byte);
        if (got.data_valid !== exp.data_valid)
          $display("%0t ns: data_valid expected %b got %b", $time, exp.data_valid,
                   got.data_valid);
        if (got.run_last !== exp.run_last)
          $display("%0t ns: run_last expected %b got %b", $time, exp.run_last,
                   got.run_last);
        if (got.entry_done !== exp.entry_done)
          $display("%0t ns: entry_done expected %b got %b", $time, exp.entry_done,
                   got.entry_done);
        if (got.bad_mode !== exp.bad_mode)
          $display("%0t ns: bad_mode expected %b got %b", $time, exp.bad_mode,
                   got.bad_mode);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_entry();
      phase = ST_IDLE;
      expected_bytes_q.delete();
      mismatches = 0;
      checked    = 0;
      pending    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      pending = expected_bytes_q.size();
    end
  end

endmodule

/* bench/lzss_entry_decompressor_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzss_entry_decompressor_unit_tb
// Feeds archive entries to the decompressor: a directed set of raw, lzss,
// bad mode and zero length entries, then random entries that are mostly
// well formed lzss or raw streams, some cut short by a restart, some with
// trailing bytes. Both sides idle in random bursts; the scoreboard checks.
// ----------------------------------------------------------------------------
module lzss_entry_decompressor_unit_tb;
  import lzed_pkg::*;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned RandomItems = 200;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lzed_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lzed_out_t out_data;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned checked_cnt;

  int unsigned sent_cnt;
  int unsigned ignored_cnt;
  int unsigned entry_cnt;
  int unsigned copy_cnt;
  int unsigned quiet_cycles;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;

  lzss_entry_decompressor_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  lzed_scoreboard u_scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt),
    .checked_o     (checked_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ns: no handshake for %0d cycles, %0d items still expected",
                 $time, QuietLimit, pending_cnt);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // output side stalls in bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic start);
    if (in_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.in_byte     <= b;
    in_data.entry_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic put_header(input logic [23:0] len, input logic [7:0] mode);
    put_byte(len[7:0], 1'b1);
    put_byte(len[15:8], 1'b0);
    put_byte(len[23:16], 1'b0);
    put_byte(mode, 1'b0);
    entry_cnt++;
  endtask

  task automatic put_noise(input int unsigned n);
    for (int i = 0; i < n; i++) put_byte($urandom_range(0, 255), 1'b0);
    ignored_cnt += n;
  endtask

  // flag, literal and reference bytes until the length is reached or cap runs out
  task automatic put_lzss_body(input int unsigned len, input int unsigned cap);
    int unsigned made;
    int unsigned used;
    logic [7:0]  flag;
    logic [3:0]  extra;
    logic [11:0] pos;
    made = 0;
    used = 0;
    while (made < len && used < cap) begin
      flag = $urandom_range(0, 255);
      put_byte(flag, 1'b0);
      used++;
      for (int k = 0; k < 8 && made < len; k++) begin
        if (flag[k]) begin
          put_byte($urandom_range(0, 255), 1'b0);
          made++;
          used++;
        end else begin
          extra = $urandom_range(0, 15);
          if (made > 0 && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, made - 1);
          end else begin
            pos = $urandom_range(0, WindowSize - 1);
          end
          put_byte(pos[7:0], 1'b0);
          put_byte({extra, pos[11:8]}, 1'b0);
          made += extra + 3;
          used += 2;
          copy_cnt++;
        end
      end
    end
  endtask

  task automatic put_raw_body(input int unsigned len, input int unsigned cap);
    for (int i = 0; i < len && i < cap; i++) put_byte($urandom_range(0, 255), 1'b0);
  endtask

  initial begin
    int unsigned    target;
    int unsigned    pick;
    logic [23:0]    len;
    logic [7:0]     mode;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any entry start are dropped
    put_noise(2);
    // raw entry with extreme byte values, then a byte after completion
    put_header(24'd3, ModeRaw);
    put_byte(8'h00, 1'b0);
    put_byte(8'hff, 1'b0);
    put_byte(8'ha5, 1'b0);
    put_noise(1);
    // all-ones header: bad mode, then an ignored byte
    put_header(24'hffffff, 8'hff);
    put_noise(1);
    // zero length lzss entry
    put_header(24'd0, ModeLzss);
    // literal, then a longest reference that overlaps itself and is cut by the length
    put_header(24'd5, ModeLzss);
    put_byte(8'h01, 1'b0);
    put_byte(8'h41, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hf0, 1'b0);
    copy_cnt++;

    target = sent_cnt - ignored_cnt + RandomItems;
    while (sent_cnt - ignored_cnt < target) begin
      if (sent_cnt - ignored_cnt + 50 > target) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(0, 24'hffffff);
      end else begin
        len = $urandom_range(0, 48);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        put_header(len, ModeLzss);
        put_lzss_body(len, $urandom_range(4, 40));
      end else if (pick < 9) begin
        put_header(len, ModeRaw);
        put_raw_body(len, $urandom_range(4, 40));
      end else begin
        do mode = $urandom_range(0, 255); while (mode == ModeRaw || mode == ModeLzss);
        put_header(len, mode);
        put_noise($urandom_range(0, 3));
      end
      if ($urandom_range(0, 3) == 0) put_noise($urandom_range(1, 3));
    end
    in_valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d input items over %0d entries with %0d window references sent",
             sent_cnt, entry_cnt, copy_cnt);
    $display("%0d output items checked", checked_cnt);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
